### rtl/core/ckt_pkg.sv
// ckt_pkg: shared types, sizes and codes for the counted key table
// used by ckt_ctrl, ckt_dpath and counted_key_table; no dependencies
package ckt_pkg;

  // table sizing
  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned KEY_WIDTH   = 16;
  localparam int unsigned COUNT_WIDTH = 16;

  // fixed port widths
  localparam int unsigned KeyInW  = 16;
  localparam int unsigned AmtInW  = 16;
  localparam int unsigned CountOW = 16;
  localparam int unsigned UsedOW  = 5;

  // derived internal widths
  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned UsedW = $clog2(CAPACITY + 1);

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [UsedW-1:0]       used_t;

  // operation codes
  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_EXTRACT = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_SHORT  = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic lookup;  // compare key against all slots, register hit and free slot
    logic exec;    // update the table and present the result
  } dp_cmd_t;

endpackage

### rtl/core/ckt_ctrl.sv
// ckt_ctrl: sequencing state machine for the counted key table
// depends on ckt_pkg for the command struct
module ckt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output ckt_pkg::dp_cmd_t cmd_o
);
  import ckt_pkg::*;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'b001,
    FSM_LOOKUP = 3'b010,
    FSM_EXEC   = 3'b100
  } fsm_e;

  fsm_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:   if (start) state_d = FSM_LOOKUP;
      FSM_LOOKUP: state_d = FSM_EXEC;
      FSM_EXEC:   state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands and handshake
  assign busy         = (state_q != FSM_IDLE);
  assign cmd_o.load   = (state_q == FSM_IDLE) && start;
  assign cmd_o.lookup = (state_q == FSM_LOOKUP);
  assign cmd_o.exec   = (state_q == FSM_EXEC);

endmodule

### rtl/core/ckt_dpath.sv
// ckt_dpath: slot registers, parallel key compare, count arithmetic and result registers
// depends on ckt_pkg; driven by commands from ckt_ctrl
module ckt_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ckt_pkg::dp_cmd_t              cmd_i,
  input  logic [1:0]                    action_i,
  input  logic [ckt_pkg::KeyInW-1:0]    key_i,
  input  logic [ckt_pkg::AmtInW-1:0]    amount_i,
  output logic                          done_o,
  output logic [ckt_pkg::CountOW-1:0]   count_after_o,
  output logic [ckt_pkg::UsedOW-1:0]    entries_used_o,
  output logic [1:0]                    status_o
);
  import ckt_pkg::*;

  // captured transaction
  action_e act_q;
  key_t    key_q;
  count_t  amt_q;

  // lookup results
  logic    hit_q, free_q;
  idx_t    hit_idx_q, free_idx_q;
  logic    hit_d, free_d;
  idx_t    hit_idx_d, free_idx_d;

  // table storage
  key_t                slot_key_q [CAPACITY];
  count_t              slot_cnt_q [CAPACITY];
  logic [CAPACITY-1:0] slot_valid_q, slot_valid_d;
  used_t               used_q, used_d;

  // result registers
  logic    done_q;
  count_t  res_cnt_q, res_cnt_d;
  status_e res_st_q, res_st_d;

  // write controls from execute step
  logic    wr_key_en, wr_cnt_en;
  idx_t    wr_idx;
  count_t  wr_cnt;
  count_t  held;
  logic [COUNT_WIDTH:0] sum;
  count_t  diff;

  // capture transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_e'(action_i);
      key_q <= key_t'(key_i);
      amt_q <= count_t'(amount_i);
    end
  end

  // parallel compare and lowest-index priority pick
  always_comb begin
    hit_d      = 1'b0;
    free_d     = 1'b0;
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && (slot_key_q[i] == key_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_t'(i);
      end
      if (!slot_valid_q[i]) begin
        free_d     = 1'b1;
        free_idx_d = idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q      <= hit_d;
      free_q     <= free_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
  end

  // execute: arithmetic and table update decisions
  assign held = slot_cnt_q[hit_idx_q];
  assign sum  = {1'b0, held} + {1'b0, amt_q};
  assign diff = held - amt_q;

  always_comb begin
    wr_key_en    = 1'b0;
    wr_cnt_en    = 1'b0;
    wr_idx       = hit_idx_q;
    wr_cnt       = held;
    slot_valid_d = slot_valid_q;
    used_d       = used_q;
    res_cnt_d    = '0;
    res_st_d     = STAT_DONE;
    case (act_q)
      ACT_ADD: begin
        if (hit_q) begin
          wr_cnt_en = 1'b1;
          wr_cnt    = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
          res_cnt_d = wr_cnt;
        end else if (free_q) begin
          wr_key_en            = 1'b1;
          wr_cnt_en            = 1'b1;
          wr_idx               = free_idx_q;
          wr_cnt               = amt_q;
          slot_valid_d[free_idx_q] = 1'b1;
          used_d               = used_q + used_t'(1);
          res_cnt_d            = amt_q;
        end else begin
          res_st_d = STAT_FULL;
        end
      end
      ACT_REMOVE: begin
        if (!hit_q) begin
          res_st_d = STAT_ABSENT;
        end else if (held < amt_q) begin
          res_st_d  = STAT_SHORT;
          res_cnt_d = held;
        end else begin
          wr_cnt_en = 1'b1;
          wr_cnt    = diff;
          res_cnt_d = diff;
          if (diff == '0) begin
            slot_valid_d[hit_idx_q] = 1'b0;
            used_d                  = used_q - used_t'(1);
          end
        end
      end
      ACT_QUERY: begin
        if (hit_q) begin
          res_cnt_d = held;
        end else begin
          res_st_d = STAT_ABSENT;
        end
      end
      ACT_EXTRACT: begin
        if (hit_q) begin
          res_cnt_d               = held;
          slot_valid_d[hit_idx_q] = 1'b0;
          used_d                  = used_q - used_t'(1);
        end else begin
          res_st_d = STAT_ABSENT;
        end
      end
      default: res_st_d = STAT_DONE;
    endcase
  end

  // slot payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_key_en) begin
      slot_key_q[wr_idx] <= key_q;
    end
    if (cmd_i.exec && wr_cnt_en) begin
      slot_cnt_q[wr_idx] <= wr_cnt;
    end
  end

  // occupancy and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      used_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        slot_valid_q <= slot_valid_d;
        used_q       <= used_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_cnt_q <= res_cnt_d;
      res_st_q  <= res_st_d;
    end
  end

  assign done_o         = done_q;
  assign count_after_o  = CountOW'(res_cnt_q);
  assign entries_used_o = UsedOW'(used_q);
  assign status_o       = res_st_q;

endmodule

### rtl/core/counted_key_table.sv
// counted_key_table: top level of a bounded key table with per-key counts
// instantiates ckt_ctrl and ckt_dpath; depends on ckt_pkg
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   command  | start, busy            | action_i, key_i, amount_i
//   result   | done_o (1-cycle pulse) | count_after_o, entries_used_o, status_o
//
// each transaction steps through capture, key compare across all slots,
// then update; done_o pulses in the cycle after the update, when busy is already
// low, so a new command can be taken in the done_o cycle but never while busy.
// reset empties the table at once; no clearing pass is needed.
// the receiver cannot stall: capture each result in the done_o cycle; the outputs hold until the next update.
module counted_key_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic [ckt_pkg::KeyInW-1:0]    key_i,
  input  logic [ckt_pkg::AmtInW-1:0]    amount_i,
  output logic                          done_o,
  output logic [ckt_pkg::CountOW-1:0]   count_after_o,
  output logic [ckt_pkg::UsedOW-1:0]    entries_used_o,
  output logic [1:0]                    status_o
);
  import ckt_pkg::*;

  dp_cmd_t cmd;

  // sequencer
  ckt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // table and arithmetic
  ckt_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .key_i          (key_i),
    .amount_i       (amount_i),
    .done_o         (done_o),
    .count_after_o  (count_after_o),
    .entries_used_o (entries_used_o),
    .status_o       (status_o)
  );

endmodule
